// File: src/mtdl_pkg.sv
// ----------------------------------------------------------------------------
// mtdl_pkg
// Shared types and constants for the multi-tap block delay line.
// ----------------------------------------------------------------------------
`default_nettype none

package mtdl_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int BLOCK_LEN   = 32;
  localparam int BLK_BITS    = 5;
  localparam int MD_BITS     = 12;
  localparam int DELAY_BITS  = 13;
  localparam int RING_BITS   = 13;
  localparam int RING_MAX    = 4096;

  localparam logic [MD_BITS-1:0] MAX_DELAY_RST = 12'd4064;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CALC,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [DELAY_BITS-1:0]         delay;
    logic                          before_add;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          status;
    logic                          last;
  } out_item_t;

  typedef struct packed {
    logic write;
    logic read;
    logic clear;
    logic sweep;
    logic calc;
    logic issue;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic calc_neg;
    logic can_issue;
    logic issue_last;
  } dp_status_t;

  // ((md == 0 ? 30 : md - 1) rounded down to a block) + two blocks
  function automatic logic [RING_BITS-1:0] ring_of(input logic [MD_BITS-1:0] md);
    logic [MD_BITS-1:0] base;
    base = (md == '0) ? MD_BITS'(30) : md - MD_BITS'(1);
    return {1'b0, base[MD_BITS-1:BLK_BITS], {BLK_BITS{1'b0}}}
           + RING_BITS'(2 * BLOCK_LEN);
  endfunction

endpackage

`default_nettype wire

// File: src/block_multitap_delay_line.sv
// ----------------------------------------------------------------------------
// block_multitap_delay_line
// Circular audio delay store filled in 32-sample blocks, read one delayed
// block of 32 samples per request.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_item  (cmd, sample, delay)
//   out      output     out_valid/out_stall  out_item (sample, status, last)
//   cfg      input      cfg_write            cfg_wdata (max_delay)
//
// Write items are taken straight from idle; a read first reduces its
// start address into the ring, then streams 32 transfers at one per
// cycle while its 2-entry output queue has room, paced by the single
// read port of the sample RAM. After reset, a clear command or a cfg
// write, the store is swept to zero one entry per cycle over ring_length
// entries (4096 after reset); no item is taken during the sweep. out_stall
// holds the queue head and throttles RAM reads without losing data.
// ----------------------------------------------------------------------------
`default_nettype none

module block_multitap_delay_line #(
  parameter int STORE_DEPTH = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire mtdl_pkg::in_item_t           in_item,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      mtdl_pkg::out_item_t          out_item,
  input  wire logic                         cfg_write,
  input  wire logic [mtdl_pkg::MD_BITS-1:0] cfg_wdata
);
  import mtdl_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  mtdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_item.cmd),
    .cfg_write(cfg_write),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  mtdl_dp #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cfg_write(cfg_write),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .st       (st),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// File: src/mtdl_ram.sv
// ----------------------------------------------------------------------------
// mtdl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/mtdl_ctrl.sv
// ----------------------------------------------------------------------------
// mtdl_ctrl
// Controller: item acceptance, clearing sweep, start reduction, block read.
// ----------------------------------------------------------------------------
`default_nettype none

module mtdl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_cmd,
  input  wire logic                cfg_write,
  input  wire mtdl_pkg::dp_status_t st,
  output      mtdl_pkg::ctl_cmd_t  cmd,
  output      logic                in_stall
);
  import mtdl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_READ) begin
            state_next = ST_CALC;
          end else if (in_cmd == CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (st.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_CALC: begin
        if (!st.calc_neg) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (st.can_issue && st.issue_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cfg_write) begin
      state_next = ST_CLEAR;
    end
  end

  always_comb begin
    cmd       = '0;
    in_stall  = (state != ST_IDLE);
    cmd.write = (state == ST_IDLE) && in_valid && (in_cmd == CMD_WRITE);
    cmd.read  = (state == ST_IDLE) && in_valid && (in_cmd == CMD_READ);
    cmd.clear = (state == ST_IDLE) && in_valid && (in_cmd == CMD_CLEAR);
    cmd.sweep = (state == ST_CLEAR);
    cmd.calc  = (state == ST_CALC);
    cmd.issue = (state == ST_READ) && st.can_issue;
  end

  ast_read_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && st.issue_last && !cfg_write) |=> (state == ST_IDLE))
    else $error("read did not return to idle after last issue");

  ast_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.write || cmd.read || cmd.clear) |-> !in_stall)
    else $error("item action while stalled");

  ast_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.write, cmd.read, cmd.clear, cmd.sweep, cmd.calc, cmd.issue}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: src/mtdl_dp.sv
// ----------------------------------------------------------------------------
// mtdl_dp
// Datapath: ring registers, sample store, read address walk, output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mtdl_dp #(
  parameter int STORE_DEPTH = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mtdl_pkg::in_item_t            in_item,
  input  wire logic                          cfg_write,
  input  wire logic [mtdl_pkg::MD_BITS-1:0]  cfg_wdata,
  input  wire mtdl_pkg::ctl_cmd_t            cmd,
  output      mtdl_pkg::dp_status_t          st,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      mtdl_pkg::out_item_t           out_item
);
  import mtdl_pkg::*;

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int BLK_I  = (STORE_DEPTH / BLOCK_LEN) * BLOCK_LEN;
  localparam int CAP_I  = (BLK_I > RING_MAX) ? RING_MAX : BLK_I;
  localparam logic [RING_BITS-1:0] RING_CAP = RING_BITS'(CAP_I);
  localparam logic [RING_BITS-1:0] BLK_R    = RING_BITS'(BLOCK_LEN);
  localparam int XW = RING_BITS + 2;

  function automatic logic [RING_BITS-1:0] ring_clamp(input logic [MD_BITS-1:0] md);
    logic [RING_BITS-1:0] len;
    len = ring_of(md);
    return (len > RING_CAP) ? RING_CAP : len;
  endfunction

  logic [MD_BITS-1:0]    max_delay;
  logic [RING_BITS-1:0]  ring;
  logic [RING_BITS-1:0]  cursor;
  logic [RING_BITS-1:0]  fill;
  logic [BLK_BITS-1:0]   offset;
  logic [RING_BITS-1:0]  clr_idx;
  logic [XW-1:0]         x;
  logic [RING_BITS-1:0]  rd_idx;
  logic [BLK_BITS-1:0]   k;
  logic                  rd_err;
  logic                  rd_zero;
  logic                  inflight;
  logic                  tag_last;
  logic                  tag_err;
  logic                  tag_zero;
  logic [1:0]            q_count;
  out_item_t             q0;
  out_item_t             q1;

  logic [RING_BITS-1:0]  ring_cfg;
  logic [RING_BITS-1:0]  ring_rst;
  logic [RING_BITS-1:0]  wr_idx;
  logic [RING_BITS-1:0]  cursor_step;
  logic [DELAY_BITS-1:0] d_eff;
  logic                  ba_err;
  logic                  range_err;
  logic                  bypass;
  logic [DELAY_BITS:0]   t_back;
  logic [XW-1:0]         x_init;
  logic [RING_BITS-1:0]  rd_idx_inc;
  logic                  pop;
  logic [2:0]            occ;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  out_item_t             push_item;

  assign ring_cfg    = ring_clamp(cfg_wdata);
  assign ring_rst    = ring_clamp(MAX_DELAY_RST);
  assign wr_idx      = cursor + RING_BITS'(offset);
  assign cursor_step = cursor + BLK_R;

  always_comb begin
    ba_err    = in_item.before_add && (in_item.delay < DELAY_BITS'(BLOCK_LEN));
    d_eff     = in_item.before_add ? in_item.delay - DELAY_BITS'(BLOCK_LEN)
                                   : in_item.delay;
    range_err = ba_err || (d_eff > {1'b0, max_delay});
    bypass    = range_err || (fill < d_eff);
    t_back    = {1'b0, d_eff} + (DELAY_BITS + 1)'(BLOCK_LEN);
    x_init    = bypass ? '0 : {2'b00, cursor} - XW'(t_back);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay <= MAX_DELAY_RST;
      ring      <= ring_rst;
      cursor    <= BLK_R;
      fill      <= '0;
      offset    <= '0;
      clr_idx   <= '0;
    end else if (cfg_write) begin
      max_delay <= cfg_wdata;
      ring      <= ring_cfg;
      cursor    <= BLK_R;
      fill      <= '0;
      offset    <= '0;
      clr_idx   <= '0;
    end else if (cmd.clear) begin
      cursor    <= BLK_R;
      fill      <= '0;
      offset    <= '0;
      clr_idx   <= '0;
    end else begin
      if (cmd.write) begin
        offset <= offset + BLK_BITS'(1);
        if (offset == BLK_BITS'(BLOCK_LEN - 1)) begin
          cursor <= (cursor_step >= ring) ? '0 : cursor_step;
          if (fill < ring) begin
            fill <= fill + BLK_R;
          end
        end
      end
      if (cmd.sweep) begin
        clr_idx <= clr_idx + RING_BITS'(1);
      end
    end
  end

  assign rd_idx_inc = (rd_idx + RING_BITS'(1) == ring) ? '0 : rd_idx + RING_BITS'(1);

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      x       <= x_init;
      rd_err  <= range_err;
      rd_zero <= bypass;
    end else if (cmd.calc) begin
      if (x[XW-1]) begin
        x <= x + {2'b00, ring};
      end else begin
        rd_idx <= x[RING_BITS-1:0];
        k      <= '0;
      end
    end else if (cmd.issue) begin
      rd_idx <= rd_idx_inc;
      k      <= k + BLK_BITS'(1);
    end
    if (cmd.issue) begin
      tag_last <= (k == BLK_BITS'(BLOCK_LEN - 1));
      tag_err  <= rd_err;
      tag_zero <= rd_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
    end else begin
      inflight <= cmd.issue;
    end
  end

  assign ram_we    = cmd.write || cmd.sweep;
  assign ram_waddr = cmd.sweep ? AW'(clr_idx) : AW'(wr_idx);
  assign ram_wdata = cmd.sweep ? '0 : in_item.sample_in;

  mtdl_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.issue),
    .raddr(AW'(rd_idx)),
    .rdata(ram_rdata)
  );

  // two-entry output queue; head drives the port
  always_comb begin
    push_item.sample_out = tag_zero ? '0 : ram_rdata;
    push_item.status     = tag_err;
    push_item.last       = tag_last;
  end

  assign pop = (q_count != 2'd0) && !out_stall;
  assign occ = {1'b0, q_count} + {2'b00, inflight} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (inflight && !pop) begin
      if (q_count == 2'd0) begin
        q0 <= push_item;
      end else begin
        q1 <= push_item;
      end
    end else if (inflight && pop) begin
      if (q_count == 2'd1) begin
        q0 <= push_item;
      end else begin
        q0 <= q1;
        q1 <= push_item;
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      q_count <= q_count + {1'b0, inflight} - {1'b0, pop};
    end
  end

  assign out_valid = (q_count != 2'd0);
  assign out_item  = q0;

  always_comb begin
    st.sweep_done = (clr_idx == ring - RING_BITS'(1));
    st.calc_neg   = x[XW-1];
    st.can_issue  = (occ <= 3'd1);
    st.issue_last = (k == BLK_BITS'(BLOCK_LEN - 1));
  end

  ast_queue_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, q_count} + {2'b00, inflight}) <= 3'd2)
    else $error("output queue overcommitted");

  ast_wr_in_ring: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> (wr_idx < ring))
    else $error("sample write outside ring");

  ast_rd_in_ring: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (rd_idx < ring))
    else $error("block read outside ring");

endmodule

`default_nettype wire
